// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the PWM meter modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define PFDM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pfdm assertion failed");
// Check that a condition never holds outside reset
`define PFDM_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("pfdm assertion failed");
`else
`define PFDM_ASSERT(label, clk, rst_n, prop)
`define PFDM_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ----- sv/pfdm_pkg.sv -----
// ----------------------------------------------------------------------------
// pfdm_pkg
// Shared constants, register indexes and types of the PWM frequency/duty meter.
// ----------------------------------------------------------------------------
package pfdm_pkg;

    // Default sizing
    localparam int COUNTER_WIDTH_DEFAULT = 32;
    localparam int QUEUE_DEPTH_DEFAULT   = 4;

    // Configuration port
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TICKS_PER_SECOND = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TIMEOUT_TICKS    = 1'b1;
    localparam logic [CFG_DATA_WIDTH-1:0]  TICKS_PER_SECOND_RESET = 32'd16000000;
    localparam logic [CFG_DATA_WIDTH-1:0]  TIMEOUT_TICKS_RESET    = 32'd16000000;

    // Request opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Result widths and limits
    localparam int FREQ_WIDTH = 32;
    localparam int DUTY_WIDTH = 7;
    localparam logic [DUTY_WIDTH-1:0] DUTY_FULL = 7'd100;

    // Classification of a read request, handed from front to back
    typedef struct packed {
        logic lost;
        logic saturated;
    } read_flags_t;

    localparam int FLAGS_WIDTH = $bits(read_flags_t);

endpackage

// ----- sv/pfdm_front.sv -----
// ----------------------------------------------------------------------------
// pfdm_front
// Request intake: runs the tick counter and edge capture on accepted ticks, holds
// the configuration registers and classifies read requests for the back end.
// ----------------------------------------------------------------------------
module pfdm_front #(
    parameter int COUNTER_WIDTH = pfdm_pkg::COUNTER_WIDTH_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // Request channel
    input  logic                                    item_valid,
    output logic                                    item_ready,
    input  logic                                    operation,
    input  logic                                    pin_level,
    // Configuration channel
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [pfdm_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [pfdm_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
    // Queue write side
    input  logic                                    queue_full,
    output logic                                    push,
    output pfdm_pkg::read_flags_t                   push_flags,
    output logic [pfdm_pkg::CFG_DATA_WIDTH-1:0]     push_tps,
    output logic [COUNTER_WIDTH-1:0]                push_period,
    output logic [COUNTER_WIDTH-1:0]                push_high
);

    localparam int CMP_WIDTH = (COUNTER_WIDTH > pfdm_pkg::CFG_DATA_WIDTH) ?
                               COUNTER_WIDTH : pfdm_pkg::CFG_DATA_WIDTH;

    logic [COUNTER_WIDTH-1:0]               counter_reg, counter_next;
    logic [COUNTER_WIDTH-1:0]               period_reg, period_next;
    logic [COUNTER_WIDTH-1:0]               high_reg, high_next;
    logic                                   level_reg, level_next;
    logic [pfdm_pkg::CFG_DATA_WIDTH-1:0]    tps_reg, tps_next;
    logic [pfdm_pkg::CFG_DATA_WIDTH-1:0]    timeout_reg, timeout_next;
    logic [COUNTER_WIDTH-1:0]               counter_inc;
    logic                                   accept;
    logic                                   tick;

    // Stall only a read that finds the queue full; ticks always go through
    assign item_ready = !((operation == pfdm_pkg::OP_READ) && queue_full);
    assign accept     = item_valid && item_ready;
    assign tick       = accept && (operation == pfdm_pkg::OP_TICK);
    assign push       = accept && (operation == pfdm_pkg::OP_READ);
    assign cfg_ready  = 1'b1;

    // Classify a read against the current capture state
    assign push_flags.lost = (CMP_WIDTH'(counter_reg) > CMP_WIDTH'(timeout_reg)) ||
                             (period_reg == '0);
    assign push_flags.saturated = (high_reg >= period_reg);
    assign push_tps    = tps_reg;
    assign push_period = period_reg;
    assign push_high   = high_reg;

    // Advance the counter and capture on pin edges
    assign counter_inc = counter_reg + COUNTER_WIDTH'(1);

    always_comb
    begin
        counter_next = counter_reg;
        period_next  = period_reg;
        high_next    = high_reg;
        level_next   = level_reg;
        if (tick)
        begin
            counter_next = counter_inc;
            level_next   = pin_level;
            if (!level_reg && pin_level)
            begin
                period_next  = counter_inc;
                counter_next = '0;
            end
            else if (level_reg && !pin_level)
            begin
                high_next = counter_inc;
            end
        end
    end

    // Decode configuration writes
    always_comb
    begin
        tps_next     = tps_reg;
        timeout_next = timeout_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pfdm_pkg::REG_TICKS_PER_SECOND: tps_next     = cfg_data;
                pfdm_pkg::REG_TIMEOUT_TICKS:    timeout_next = cfg_data;
                default:
                begin
                    tps_next     = tps_reg;
                    timeout_next = timeout_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            period_reg  <= '0;
            high_reg    <= '0;
            level_reg   <= 1'b1;
            tps_reg     <= pfdm_pkg::TICKS_PER_SECOND_RESET;
            timeout_reg <= pfdm_pkg::TIMEOUT_TICKS_RESET;
        end
        else
        begin
            counter_reg <= counter_next;
            period_reg  <= period_next;
            high_reg    <= high_next;
            level_reg   <= level_next;
            tps_reg     <= tps_next;
            timeout_reg <= timeout_next;
        end
    end

endmodule

// ----- sv/pfdm_queue.sv -----
// ----------------------------------------------------------------------------
// pfdm_queue
// Small FIFO of classified read requests between front and back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfdm_queue #(
    parameter int DATA_WIDTH = 8,
    parameter int DEPTH      = pfdm_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [DATA_WIDTH-1:0] push_data,
    input  logic                  pop,
    output logic [DATA_WIDTH-1:0] pop_data,
    output logic                  full,
    output logic                  empty
);

    localparam int PTR_WIDTH   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0]  mem [DEPTH];
    logic [PTR_WIDTH-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_WIDTH-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    assign full     = (count_reg == COUNT_WIDTH'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    // Step pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_WIDTH'(DEPTH - 1)) ? '0 :
                          wr_ptr_reg + PTR_WIDTH'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_WIDTH'(DEPTH - 1)) ? '0 :
                          rd_ptr_reg + PTR_WIDTH'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + COUNT_WIDTH'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    `PFDM_ASSERT_NEVER(a_push_full, clk, rst_n, push && full)
    `PFDM_ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && empty)
    `PFDM_ASSERT(a_empty_ptrs, clk, rst_n, empty |-> wr_ptr_reg == rd_ptr_reg)

endmodule

// ----- sv/pfdm_back.sv -----
// ----------------------------------------------------------------------------
// pfdm_back
// Read execution: one shared restoring divider, one quotient bit per cycle,
// computes rounded frequency then rounded duty; lost: zeros, saturated: 100.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfdm_back #(
    parameter int COUNTER_WIDTH = pfdm_pkg::COUNTER_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Queue read side
    input  logic                                queue_empty,
    output logic                                pop,
    input  pfdm_pkg::read_flags_t               entry_flags,
    input  logic [pfdm_pkg::CFG_DATA_WIDTH-1:0] entry_tps,
    input  logic [COUNTER_WIDTH-1:0]            entry_period,
    input  logic [COUNTER_WIDTH-1:0]            entry_high,
    // Result channel
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [pfdm_pkg::FREQ_WIDTH-1:0]     frequency_hz,
    output logic [pfdm_pkg::DUTY_WIDTH-1:0]     duty_pct,
    output logic                                signal_lost
);

    // Dividend width covers tps + period/2 and high*100 + period/2
    localparam int DNW  = ((COUNTER_WIDTH + 7) > 33) ? (COUNTER_WIDTH + 7) : 33;
    localparam int CNTW = $clog2(DNW + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FREQ = 2'd1;
    localparam logic [1:0] ST_DUTY = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                         state_reg, state_next;
    logic [CNTW-1:0]                    cnt_reg, cnt_next;
    logic [DNW-1:0]                     quot_reg, quot_next;
    logic [COUNTER_WIDTH-1:0]           rem_reg, rem_next;
    logic [COUNTER_WIDTH-1:0]           divisor_reg, divisor_next;
    logic [DNW-1:0]                     prod_reg, prod_next;
    logic                               sat_reg, sat_next;
    logic [pfdm_pkg::FREQ_WIDTH-1:0]    freq_reg, freq_next;
    logic [pfdm_pkg::DUTY_WIDTH-1:0]    duty_reg, duty_next;
    logic                               lost_reg, lost_next;

    logic [COUNTER_WIDTH:0]             rem_shift;
    logic [COUNTER_WIDTH:0]             rem_diff;
    logic                               q_bit;
    logic [COUNTER_WIDTH-1:0]           rem_step;
    logic [DNW-1:0]                     quot_step;
    logic                               last_step;
    logic [COUNTER_WIDTH-1:0]           entry_half;
    logic [COUNTER_WIDTH-1:0]           divisor_half;
    logic [DNW-1:0]                     freq_num;
    logic [DNW-1:0]                     high_x100;

    // One restoring division step
    assign rem_shift = {rem_reg, quot_reg[DNW-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};
    assign q_bit     = (rem_shift >= {1'b0, divisor_reg});
    assign rem_step  = q_bit ? rem_diff[COUNTER_WIDTH-1:0] : rem_shift[COUNTER_WIDTH-1:0];
    assign quot_step = {quot_reg[DNW-2:0], q_bit};
    assign last_step = (cnt_reg == CNTW'(1));

    // Operand setup: rounding offsets and high time scaled by 100
    assign entry_half   = entry_period >> 1;
    assign divisor_half = divisor_reg >> 1;
    assign freq_num     = DNW'(entry_tps) + DNW'(entry_half);
    assign high_x100    = (DNW'(entry_high) << 6) + (DNW'(entry_high) << 5) +
                          (DNW'(entry_high) << 2);

    assign pop          = (state_reg == ST_IDLE) && !queue_empty;
    assign result_valid = (state_reg == ST_DONE);
    assign frequency_hz = freq_reg;
    assign duty_pct     = duty_reg;
    assign signal_lost  = lost_reg;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        prod_next    = prod_reg;
        sat_next     = sat_reg;
        freq_next    = freq_reg;
        duty_next    = duty_reg;
        lost_next    = lost_reg;
        case (state_reg)
            ST_IDLE:
            begin
                // Take the next request; a lost signal reports zeros at once
                if (!queue_empty)
                begin
                    lost_next = entry_flags.lost;
                    if (entry_flags.lost)
                    begin
                        freq_next  = '0;
                        duty_next  = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        quot_next    = freq_num;
                        rem_next     = '0;
                        cnt_next     = CNTW'(DNW);
                        divisor_next = entry_period;
                        prod_next    = high_x100;
                        sat_next     = entry_flags.saturated;
                        state_next   = ST_FREQ;
                    end
                end
            end
            ST_FREQ:
            begin
                quot_next = quot_step;
                rem_next  = rem_step;
                cnt_next  = cnt_reg - CNTW'(1);
                if (last_step)
                begin
                    freq_next = quot_step[pfdm_pkg::FREQ_WIDTH-1:0];
                    if (sat_reg)
                    begin
                        duty_next  = pfdm_pkg::DUTY_FULL;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        // Load high*100 + period/2 for the duty division
                        quot_next  = prod_reg + DNW'(divisor_half);
                        rem_next   = '0;
                        cnt_next   = CNTW'(DNW);
                        state_next = ST_DUTY;
                    end
                end
            end
            ST_DUTY:
            begin
                quot_next = quot_step;
                rem_next  = rem_step;
                cnt_next  = cnt_reg - CNTW'(1);
                if (last_step)
                begin
                    duty_next  = quot_step[pfdm_pkg::DUTY_WIDTH-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold the result until the receiver takes it
                if (result_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        prod_reg    <= prod_next;
        sat_reg     <= sat_next;
        freq_reg    <= freq_next;
        duty_reg    <= duty_next;
        lost_reg    <= lost_next;
    end

    `PFDM_ASSERT(a_lost_zero, clk, rst_n, result_valid && lost_reg |-> {freq_reg, duty_reg} == '0)
    `PFDM_ASSERT(a_duty_range, clk, rst_n, result_valid |-> duty_pct <= pfdm_pkg::DUTY_FULL)
    `PFDM_ASSERT(a_div_count, clk, rst_n, (state_reg == ST_FREQ || state_reg == ST_DUTY) |-> cnt_reg != '0)
    `PFDM_ASSERT(a_pop_leaves_idle, clk, rst_n, pop |=> state_reg != ST_IDLE)

endmodule

// ----- sv/pwm_frequency_duty_meter_core.sv -----
// ----------------------------------------------------------------------------
// pwm_frequency_duty_meter_core
// PWM input meter: captures period and high time of a sampled pin and
// reports rounded frequency and duty cycle on request.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (item_valid/item_ready, operation, pin_level): a tick
//   request advances the tick counter and captures on pin edges in the cycle
//   it is accepted, one tick per clock. A read request snapshots the capture
//   state into a queue of QUEUE_DEPTH entries; item_ready drops only for a
//   read that meets a full queue, so ticks are never held off.
//   Result channel (result_valid/result_ready): one result per read, in order.
//   Results come from the single bit-serial divider, one read at a time: it
//   runs the frequency division, then the duty division (skipped when duty
//   saturates; both are skipped when the signal is lost). A stalled result
//   holds the divider; ticks keep being taken.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0
//   is ticks_per_second, index 1 is timeout_ticks; cfg_ready is always high.
//   Reset clears counter and captures, sets the previous pin level high and
//   loads both registers with 16000000.
// ----------------------------------------------------------------------------
module pwm_frequency_duty_meter_core #(
    parameter int COUNTER_WIDTH = pfdm_pkg::COUNTER_WIDTH_DEFAULT,
    parameter int QUEUE_DEPTH   = pfdm_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic                                operation,
    input  logic                                pin_level,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [pfdm_pkg::FREQ_WIDTH-1:0]     frequency_hz,
    output logic [pfdm_pkg::DUTY_WIDTH-1:0]     duty_pct,
    output logic                                signal_lost,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pfdm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [pfdm_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);

    localparam int TPS_W   = pfdm_pkg::CFG_DATA_WIDTH;
    localparam int ENTRY_W = pfdm_pkg::FLAGS_WIDTH + TPS_W + 2 * COUNTER_WIDTH;

    logic                       push;
    logic                       pop;
    logic                       queue_full;
    logic                       queue_empty;
    pfdm_pkg::read_flags_t      push_flags;
    pfdm_pkg::read_flags_t      entry_flags;
    logic [TPS_W-1:0]           push_tps;
    logic [TPS_W-1:0]           entry_tps;
    logic [COUNTER_WIDTH-1:0]   push_period;
    logic [COUNTER_WIDTH-1:0]   entry_period;
    logic [COUNTER_WIDTH-1:0]   push_high;
    logic [COUNTER_WIDTH-1:0]   entry_high;
    logic [ENTRY_W-1:0]         push_data;
    logic [ENTRY_W-1:0]         pop_data;

    pfdm_front #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .operation   (operation),
        .pin_level   (pin_level),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .queue_full  (queue_full),
        .push        (push),
        .push_flags  (push_flags),
        .push_tps    (push_tps),
        .push_period (push_period),
        .push_high   (push_high)
    );

    // Pack and unpack queue entries
    assign push_data    = {push_flags, push_tps, push_period, push_high};
    assign entry_flags  = pop_data[ENTRY_W-1 -: pfdm_pkg::FLAGS_WIDTH];
    assign entry_tps    = pop_data[2*COUNTER_WIDTH +: TPS_W];
    assign entry_period = pop_data[COUNTER_WIDTH +: COUNTER_WIDTH];
    assign entry_high   = pop_data[0 +: COUNTER_WIDTH];

    pfdm_queue #(
        .DATA_WIDTH (ENTRY_W),
        .DEPTH      (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    pfdm_back #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (queue_empty),
        .pop          (pop),
        .entry_flags  (entry_flags),
        .entry_tps    (entry_tps),
        .entry_period (entry_period),
        .entry_high   (entry_high),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .frequency_hz (frequency_hz),
        .duty_pct     (duty_pct),
        .signal_lost  (signal_lost)
    );

endmodule
